[hdl/mwsf_pkg.sv]
// Shared constants and types for the multi-word substring filter.
`timescale 1ns / 1ps
package mwsf_pkg;

  localparam int WORD_COUNT = 16;
  localparam int WORD_BYTES = 32;

  localparam int SLOT_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int USED_W = $clog2(WORD_COUNT + 1);
  localparam int POS_W  = $clog2(WORD_BYTES + 1);
  localparam int ROW_W  = WORD_BYTES * 8;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [POS_W-1:0] pos_t;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_SCAN  = 2'd2;

  localparam logic [1:0] STAT_STORED   = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_TOO_LONG = 2'd2;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

endpackage

[hdl/multi_word_substring_filter_top.sv]
// Top level of the multi-word substring filter: control sequencer and state.
// Load and clear transactions are taken in ST_IDLE; the last byte of a load registers its result for the next cycle.
// A scan byte moves the sequencer to ST_SCAN, which sweeps the stored slots one per cycle
// through the shared compare unit, fed from the word RAM read port, and then to ST_FIN.
// The verdict of a message is registered in ST_FIN after the sweep for its last byte, once the output is free.
// Synchronous active-low reset empties the table and clears the scan state.
`timescale 1ns / 1ps
module multi_word_substring_filter_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [1:0] in_tuser,   // [1:0] mode
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] found, [2:1] load_status, [7:3] zero
  output logic       out_tuser   // [0] kind
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam int CNT_W = $clog2(mwsf_pkg::WORD_COUNT + 1);

  logic [1:0]                  state_r, state_nxt;
  logic [mwsf_pkg::USED_W-1:0] used_r, used_nxt;
  mwsf_pkg::pos_t              load_pos_r, load_pos_nxt;
  logic                        too_long_r, too_long_nxt;
  mwsf_pkg::row_t              load_word_r, load_word_nxt;
  mwsf_pkg::pos_t              len_r [mwsf_pkg::WORD_COUNT];
  mwsf_pkg::pos_t              len_nxt [mwsf_pkg::WORD_COUNT];
  logic [mwsf_pkg::WORD_COUNT-1:0] valid_r, valid_nxt;
  mwsf_pkg::row_t              win_r, win_nxt;
  mwsf_pkg::pos_t              fill_r, fill_nxt;
  logic                        match_r, match_nxt;
  logic                        last_r, last_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        cmp_en_r, cmp_en_nxt;
  logic [mwsf_pkg::SLOT_W-1:0] cmp_slot_r, cmp_slot_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_kind_r, out_kind_nxt;
  logic                        out_found_r, out_found_nxt;
  logic [1:0]                  out_stat_r, out_stat_nxt;

  logic                        out_free;
  logic                        acc;
  logic                        room;
  logic                        full;
  logic                        tl_cur;
  mwsf_pkg::row_t              word_cur;
  mwsf_pkg::pos_t              pos_cur;
  logic                        ram_we;
  logic                        ram_re;
  mwsf_pkg::row_t              ram_rdata;
  logic                        hit;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign acc       = in_tvalid && in_tready;

  // Load byte bookkeeping; bytes past WORD_BYTES are dropped and mark the word.
  assign room     = load_pos_r < mwsf_pkg::POS_W'(mwsf_pkg::WORD_BYTES);
  assign full     = used_r >= mwsf_pkg::USED_W'(mwsf_pkg::WORD_COUNT);
  assign tl_cur   = too_long_r || !room;
  assign word_cur = room ? ((load_word_r << 8) | mwsf_pkg::ROW_W'(in_tdata)) : load_word_r;
  assign pos_cur  = room ? load_pos_r + mwsf_pkg::POS_W'(1) : load_pos_r;

  assign ram_we = acc && (in_tuser == mwsf_pkg::MODE_LOAD) && in_tlast && !full && !tl_cur;
  assign ram_re = (state_r == ST_SCAN) && (cnt_r < CNT_W'(mwsf_pkg::WORD_COUNT));

  mwsf_ram #(
    .WIDTH (mwsf_pkg::ROW_W),
    .DEPTH (mwsf_pkg::WORD_COUNT)
  ) u_word_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (used_r[mwsf_pkg::SLOT_W-1:0]),
    .wdata (word_cur),
    .re    (ram_re),
    .raddr (cnt_r[mwsf_pkg::SLOT_W-1:0]),
    .rdata (ram_rdata)
  );

  mwsf_cmp u_cmp (
    .en     (cmp_en_r && valid_r[cmp_slot_r]),
    .word   (ram_rdata),
    .window (win_r),
    .len    (len_r[cmp_slot_r]),
    .fill   (fill_r),
    .hit    (hit)
  );

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    load_pos_nxt  = load_pos_r;
    too_long_nxt  = too_long_r;
    load_word_nxt = load_word_r;
    len_nxt       = len_r;
    valid_nxt     = valid_r;
    win_nxt       = win_r;
    fill_nxt      = fill_r;
    match_nxt     = match_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    cmp_en_nxt    = ram_re;
    cmp_slot_nxt  = cnt_r[mwsf_pkg::SLOT_W-1:0];
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_found_nxt = out_found_r;
    out_stat_nxt  = out_stat_r;

    if (cmp_en_r && hit) begin
      match_nxt = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_tuser)
            mwsf_pkg::MODE_CLEAR: begin
              used_nxt     = '0;
              load_pos_nxt = '0;
              too_long_nxt = 1'b0;
              valid_nxt    = '0;
              for (int s = 0; s < mwsf_pkg::WORD_COUNT; s++) begin
                len_nxt[s] = '0;
              end
            end
            mwsf_pkg::MODE_LOAD: begin
              load_word_nxt = word_cur;
              if (in_tlast) begin
                load_pos_nxt  = '0;
                too_long_nxt  = 1'b0;
                out_valid_nxt = 1'b1;
                out_kind_nxt  = mwsf_pkg::KIND_LOAD;
                out_found_nxt = 1'b0;
                if (full) begin
                  out_stat_nxt = mwsf_pkg::STAT_FULL;
                end else if (tl_cur) begin
                  out_stat_nxt = mwsf_pkg::STAT_TOO_LONG;
                end else begin
                  out_stat_nxt = mwsf_pkg::STAT_STORED;
                  len_nxt[used_r[mwsf_pkg::SLOT_W-1:0]]   = pos_cur;
                  valid_nxt[used_r[mwsf_pkg::SLOT_W-1:0]] = 1'b1;
                  used_nxt = used_r + mwsf_pkg::USED_W'(1);
                end
              end else begin
                load_pos_nxt = pos_cur;
                too_long_nxt = tl_cur;
              end
            end
            mwsf_pkg::MODE_SCAN: begin
              win_nxt  = (win_r << 8) | mwsf_pkg::ROW_W'(in_tdata);
              if (fill_r < mwsf_pkg::POS_W'(mwsf_pkg::WORD_BYTES)) begin
                fill_nxt = fill_r + mwsf_pkg::POS_W'(1);
              end
              last_nxt  = in_tlast;
              cnt_nxt   = '0;
              state_nxt = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Slot c is read at count c and compared in the cycle after.
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(mwsf_pkg::WORD_COUNT)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mwsf_pkg::KIND_SCAN;
          out_found_nxt = match_r;
          out_stat_nxt  = mwsf_pkg::STAT_STORED;
          match_nxt     = 1'b0;
          fill_nxt      = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      load_pos_r  <= '0;
      too_long_r  <= 1'b0;
      valid_r     <= '0;
      fill_r      <= '0;
      match_r     <= 1'b0;
      last_r      <= 1'b0;
      cnt_r       <= '0;
      cmp_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < mwsf_pkg::WORD_COUNT; s++) begin
        len_r[s] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      load_pos_r  <= load_pos_nxt;
      too_long_r  <= too_long_nxt;
      valid_r     <= valid_nxt;
      fill_r      <= fill_nxt;
      match_r     <= match_nxt;
      last_r      <= last_nxt;
      cnt_r       <= cnt_nxt;
      cmp_en_r    <= cmp_en_nxt;
      out_valid_r <= out_valid_nxt;
      len_r       <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    load_word_r <= load_word_nxt;
    win_r       <= win_nxt;
    cmp_slot_r  <= cmp_slot_nxt;
    out_kind_r  <= out_kind_nxt;
    out_found_r <= out_found_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {5'b0, out_stat_r, out_found_r};

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= mwsf_pkg::USED_W'(mwsf_pkg::WORD_COUNT))
    else $error("slot count past table size");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= mwsf_pkg::POS_W'(mwsf_pkg::WORD_BYTES))
    else $error("window fill past window size");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("input taken while scanning");

  a_cmp_only_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_en_r |-> (state_r == ST_SCAN))
    else $error("compare outside scan sweep");

  a_scan_verdict_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == mwsf_pkg::KIND_SCAN)) |->
      (out_stat_r == mwsf_pkg::STAT_STORED))
    else $error("scan verdict carries load status");

  a_load_outcome_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == mwsf_pkg::KIND_LOAD)) |-> !out_found_r)
    else $error("load outcome carries match flag");

endmodule

[hdl/mwsf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mwsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/mwsf_cmp.sv]
// Shared compare unit: one stored word against the message history window.
`timescale 1ns / 1ps
module mwsf_cmp (
  input  logic             en,
  input  mwsf_pkg::row_t   word,    // newest-aligned: byte 0 is the word's last byte
  input  mwsf_pkg::row_t   window,  // byte 0 is the newest message byte
  input  mwsf_pkg::pos_t   len,
  input  mwsf_pkg::pos_t   fill,
  output logic             hit
);

  logic [mwsf_pkg::WORD_BYTES-1:0] byte_ok;

  always_comb begin
    for (int i = 0; i < mwsf_pkg::WORD_BYTES; i++) begin
      byte_ok[i] = (mwsf_pkg::POS_W'(i) >= len) ||
                   (word[i*8 +: 8] == window[i*8 +: 8]);
    end
  end

  assign hit = en && (len != '0) && (len <= fill) && (&byte_ok);

endmodule

[verif/mwsf_checker.sv]
// Checker for the multi-word substring filter: predicts load outcomes and scan verdicts.
`timescale 1ns / 1ps
module mwsf_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic [1:0] in_tuser,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic       out_tuser,
  output int         error_count,
  output int         outstanding
);

  typedef struct packed {
    logic       kind;
    logic       found;
    logic [1:0] status;
  } outcome_t;

  logic [7:0] slot_bytes [mwsf_pkg::WORD_COUNT][mwsf_pkg::WORD_BYTES];
  int         slot_len [mwsf_pkg::WORD_COUNT];
  bit         slot_ok [mwsf_pkg::WORD_COUNT];
  int         slots_filled;
  int         entry_pos;
  bit         entry_overflow;
  logic [7:0] recent [mwsf_pkg::WORD_BYTES];
  int         recent_fill;
  bit         hit_seen;
  int         misses = 0;
  outcome_t   outcome_q [$];

  task automatic empty_table();
    foreach (slot_len[s]) begin
      slot_len[s] = 0;
      slot_ok[s]  = 1'b0;
    end
    slots_filled   = 0;
    entry_pos      = 0;
    entry_overflow = 1'b0;
  endtask

  task automatic flush_window();
    foreach (recent[i]) recent[i] = 8'h00;
    recent_fill = 0;
    hit_seen    = 1'b0;
  endtask

  // recent[0] is the newest byte, so a word ends at recent[0]
  function automatic bit slot_hit(int s);
    if (slot_len[s] == 0 || slot_len[s] > recent_fill) return 1'b0;
    for (int k = 0; k < slot_len[s]; k++)
      if (slot_bytes[s][k] !== recent[slot_len[s] - 1 - k]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic absorb_item(input logic [1:0] mode, input logic [7:0] b, input logic last);
    outcome_t res;
    res = '0;
    case (mode)
      mwsf_pkg::MODE_CLEAR: empty_table();
      mwsf_pkg::MODE_LOAD: begin
        if (entry_pos < mwsf_pkg::WORD_BYTES) begin
          if (slots_filled < mwsf_pkg::WORD_COUNT) slot_bytes[slots_filled][entry_pos] = b;
          entry_pos++;
        end else begin
          entry_overflow = 1'b1;
        end
        if (last) begin
          res.kind = mwsf_pkg::KIND_LOAD;
          // full wins over too long
          if (slots_filled >= mwsf_pkg::WORD_COUNT) begin
            res.status = mwsf_pkg::STAT_FULL;
          end else if (entry_overflow) begin
            res.status = mwsf_pkg::STAT_TOO_LONG;
          end else begin
            slot_len[slots_filled] = entry_pos;
            slot_ok[slots_filled]  = 1'b1;
            slots_filled++;
            res.status = mwsf_pkg::STAT_STORED;
          end
          entry_pos      = 0;
          entry_overflow = 1'b0;
          outcome_q.push_back(res);
        end
      end
      mwsf_pkg::MODE_SCAN: begin
        for (int i = mwsf_pkg::WORD_BYTES - 1; i > 0; i--) recent[i] = recent[i - 1];
        recent[0] = b;
        if (recent_fill < mwsf_pkg::WORD_BYTES) recent_fill++;
        for (int s = 0; s < mwsf_pkg::WORD_COUNT; s++)
          if (slot_ok[s] && slot_hit(s)) hit_seen = 1'b1;
        if (last) begin
          res.kind  = mwsf_pkg::KIND_SCAN;
          res.found = hit_seen;
          outcome_q.push_back(res);
          flush_window();
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      empty_table();
      flush_window();
      outcome_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (outcome_q.size() == 0) begin
          misses++;
          if (misses <= 10)
            $display("%0t: result with nothing expected: kind %0b found %0b status %0d",
                     $realtime, out_tuser, out_tdata[0], out_tdata[2:1]);
        end else begin
          want = outcome_q.pop_front();
          if (want.kind !== out_tuser || want.found !== out_tdata[0] ||
              want.status !== out_tdata[2:1]) begin
            misses++;
            if (misses <= 10)
              $display("%0t: mismatch: expected kind %0b found %0b status %0d, got %0b %0b %0d",
                       $realtime, want.kind, want.found, want.status,
                       out_tuser, out_tdata[0], out_tdata[2:1]);
          end
        end
      end
      if (in_tvalid && in_tready) absorb_item(in_tuser, in_tdata, in_tlast);
    end
    error_count <= misses;
    outstanding <= outcome_q.size();
  end

endmodule

[verif/tb_multi_word_substring_filter_top.sv]
// Testbench top for the multi-word substring filter: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_multi_word_substring_filter_top;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int ITEM_GOAL    = 1850;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 4 * (mwsf_pkg::WORD_COUNT + 3);

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic [1:0] in_tuser;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tuser;

  int         error_count;
  int         outstanding;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_request = 1'b0;
  bit         hold_done = 1'b0;
  int         sent_items = 0;
  int         quiet_cycles = 0;

  // last few words entered, replayed inside messages to provoke hits
  logic [7:0] word_pool [4][40];
  int         pool_len [4];
  int         pool_next = 0;
  int         pool_count = 0;

  multi_word_substring_filter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  mwsf_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_multi_word_substring_filter_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'h61 + 8'($urandom_range(3));
    if (r < 75) return 8'h00;
    return 8'($urandom_range(255));
  endfunction

  // called and returns at a falling edge; valid stays high unless the sender idles
  task automatic send_byte(input logic [1:0] mode, input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = b;
    in_tlast  = last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (mode != MODE_UNUSED) sent_items++;
    @(negedge clk);
  endtask

  task automatic send_word(input int len, input bit wide_bytes);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = wide_bytes ? 8'($urandom_range(255)) : pick_byte();
      if (i < 40) word_pool[pool_next][i] = b;
      send_byte(mwsf_pkg::MODE_LOAD, b, i == len - 1);
    end
    pool_len[pool_next] = (len < 40) ? len : 40;
    pool_next = (pool_next + 1) % 4;
    if (pool_count < 4) pool_count++;
  endtask

  task automatic send_message(input int len, input bit embed);
    logic [7:0] msg [$];
    int p;
    int at;
    for (int i = 0; i < len; i++) msg.push_back(pick_byte());
    if (embed && pool_count > 0) begin
      p  = $urandom_range(pool_count - 1);
      at = $urandom_range(len);
      for (int k = pool_len[p] - 1; k >= 0; k--) msg.insert(at, word_pool[p][k]);
    end
    foreach (msg[i]) send_byte(mwsf_pkg::MODE_SCAN, msg[i], i == msg.size() - 1);
  endtask

  task automatic random_sequence();
    int r;
    int len;
    r = $urandom_range(99);
    if (r < 34) begin
      r = $urandom_range(99);
      len = (r < 80) ? $urandom_range(1, 5) :
            (r < 90) ? $urandom_range(mwsf_pkg::WORD_BYTES - 2, mwsf_pkg::WORD_BYTES) :
                       $urandom_range(mwsf_pkg::WORD_BYTES + 1, mwsf_pkg::WORD_BYTES + 4);
      send_word(len, $urandom_range(9) == 0);
    end else if (r < 88) begin
      r = $urandom_range(99);
      len = (r < 70) ? $urandom_range(1, 10) :
            (r < 90) ? $urandom_range(11, 24) : $urandom_range(28, 40);
      send_message(len, $urandom_range(1));
    end else if (r < 89) begin
      send_byte(mwsf_pkg::MODE_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end else if (r < 93) begin
      send_byte(MODE_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end else begin
      // broken sequences: any mode, any byte, any last
      repeat ($urandom_range(1, 3))
        send_byte(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tuser  = mwsf_pkg::MODE_CLEAR;
    in_tlast  = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed part
    send_byte(MODE_UNUSED, 8'hFF, 1'b1);
    send_byte(mwsf_pkg::MODE_SCAN, 8'h61, 1'b1);       // empty table, no hit
    send_byte(mwsf_pkg::MODE_LOAD, 8'h00, 1'b1);       // zero byte word
    send_byte(mwsf_pkg::MODE_LOAD, 8'hFF, 1'b1);
    send_byte(mwsf_pkg::MODE_SCAN, 8'h00, 1'b0);
    send_byte(mwsf_pkg::MODE_SCAN, 8'h41, 1'b1);       // hit on the zero byte
    send_byte(mwsf_pkg::MODE_LOAD, 8'h61, 1'b0);
    send_byte(mwsf_pkg::MODE_CLEAR, 8'h00, 1'b0);      // abandons the partial word
    send_byte(mwsf_pkg::MODE_LOAD, 8'h62, 1'b1);
    send_byte(mwsf_pkg::MODE_SCAN, 8'h62, 1'b0);       // hit seen mid-message
    send_byte(mwsf_pkg::MODE_CLEAR, 8'hFF, 1'b1);      // scan state survives the clear
    send_byte(mwsf_pkg::MODE_SCAN, 8'h78, 1'b1);
    send_byte(mwsf_pkg::MODE_LOAD, 8'h63, 1'b0);
    send_byte(MODE_UNUSED, 8'h00, 1'b0);               // ignored inside a word
    send_byte(mwsf_pkg::MODE_LOAD, 8'h64, 1'b1);
    send_byte(mwsf_pkg::MODE_SCAN, 8'h63, 1'b0);
    send_byte(mwsf_pkg::MODE_SCAN, 8'h64, 1'b1);
    send_byte(mwsf_pkg::MODE_SCAN, 8'hFF, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      // overfill the table so full status shows up in every phase
      repeat (mwsf_pkg::WORD_COUNT + 2) send_word($urandom_range(2, 3), 1'b1);
      while (sent_items < ITEM_GOAL * (ph + 1) / 4) begin
        if (ph == 0 && sent_items > ITEM_GOAL / 8 && !hold_request && sent_items < ITEM_GOAL / 6)
        begin
          hold_request = 1'b1;
          repeat (40) send_byte(mwsf_pkg::MODE_SCAN, pick_byte(), 1'b1);
        end
        random_sequence();
      end
    end
    in_tvalid = 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_multi_word_substring_filter_top: clean");
    end else begin
      $display("tb_multi_word_substring_filter_top: errors");
    end
    $finish;
  end

endmodule
